// File: rtl/core/qla_pkg.sv
// Shared types and constants of the Q-learning agent: request and scan codes,
// controller states, register indexes and the command/status structs.
// No dependencies; every other file of the block imports this package.
package qla_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int RATE_W     = 17;
  localparam int RAND_W     = 16;
  localparam int PICK_IW    = 4;
  localparam int Q_W        = 32;

  localparam logic [RATE_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [4:0]        RST_ACTIONS = 5'd16;
  localparam logic [RATE_W-1:0] RST_ALPHA   = 17'd6554;
  localparam logic [RATE_W-1:0] RST_GAMMA   = 17'd58982;
  localparam logic [RATE_W-1:0] RST_DECAY   = 17'd66;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIONS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd5;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_CHOOSE = 2'd1,
    REQ_REWARD = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    SCAN_STATS      = 2'd0,
    SCAN_PICK_VALID = 2'd1,
    SCAN_PICK_TOP   = 2'd2
  } scan_mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_STATS,
    ST_DIV,
    ST_PICK,
    ST_RD_WAIT,
    ST_NSTART,
    ST_NSCAN,
    ST_MUL_G,
    ST_TGT,
    ST_MUL_A,
    ST_WB,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic       clear;
    logic       latch_in;
    logic       res_clear;
    logic       load_wr;
    logic       rd_entry;
    logic       entry_latch;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       scan_from_next;
    logic       div_start;
    logic       no_valid;
    logic       commit;
    logic       mul_g;
    logic       tgt;
    logic       mul_a;
    logic       wb;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic clr_done;
    logic scan_busy;
    logic div_busy;
    logic count_zero;
    logic explore_hit;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/qla_ctrl.sv
// Controller of the Q-learning agent: one state machine that sequences the
// clearing pass, table loads, action choice and the Q update. Uses qla_pkg.
module qla_ctrl import qla_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.scan_mode = SCAN_STATS;
    in_stall      = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.res_clear = 1'b1;
        unique case (sts.req)
          REQ_CHOOSE: begin
            cmd.scan_start = 1'b1;
            state_next     = ST_STATS;
          end
          REQ_REWARD: begin
            cmd.rd_entry = 1'b1;
            state_next   = ST_RD_WAIT;
          end
          default: begin
            cmd.load_wr = 1'b1;
            state_next  = ST_DONE;
          end
        endcase
      end
      ST_STATS: begin
        if (!sts.scan_busy) begin
          if (sts.count_zero) begin
            cmd.no_valid = 1'b1;
            state_next   = ST_DONE;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = sts.explore_hit ? SCAN_PICK_VALID : SCAN_PICK_TOP;
          state_next     = ST_PICK;
        end
      end
      ST_PICK: begin
        if (!sts.scan_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_RD_WAIT: begin
        cmd.entry_latch = 1'b1;
        state_next      = ST_NSTART;
      end
      ST_NSTART: begin
        cmd.scan_start     = 1'b1;
        cmd.scan_from_next = 1'b1;
        state_next         = ST_NSCAN;
      end
      ST_NSCAN: begin
        if (!sts.scan_busy) state_next = ST_MUL_G;
      end
      ST_MUL_G: begin
        cmd.mul_g  = 1'b1;
        state_next = ST_TGT;
      end
      ST_TGT: begin
        cmd.tgt    = 1'b1;
        state_next = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = ST_WB;
      end
      ST_WB: begin
        cmd.wb     = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == ST_DECODE)
    else $error("accepted item not decoded");
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> in_stall)
    else $error("input taken during clearing pass");
  a_done_waits_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !sts.out_free) |=> state == ST_DONE)
    else $error("result dropped while output register full");

endmodule

// File: rtl/core/qla_dp.sv
// Datapath of the Q-learning agent: Q, valid and next-state memories, the
// action scanner, the remainder unit, the update multipliers and the output
// register. Uses qla_pkg; driven by qla_ctrl.
module qla_dp import qla_pkg::*; #(
  parameter int MAX_STATES  = 256,
  parameter int MAX_ACTIONS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            req_type,
  input  logic [7:0]            table_state,
  input  logic [3:0]            table_action,
  input  logic                  table_valid,
  input  logic [7:0]            table_next,
  input  logic [RAND_W-1:0]     rand_explore,
  input  logic [RAND_W-1:0]     rand_pick,
  input  logic signed [Q_W-1:0] reward,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [3:0]            action,
  output logic                  explored,
  output logic                  status,
  output logic signed [Q_W-1:0] new_q,
  output logic [RATE_W-1:0]     epsilon_now,
  output logic [7:0]            state_now
);

  localparam int SW      = $clog2(MAX_STATES);
  localparam int AW      = $clog2(MAX_ACTIONS);
  localparam int CW      = $clog2(MAX_ACTIONS + 1);
  localparam int ENTRIES = MAX_STATES * MAX_ACTIONS;
  localparam int EW      = $clog2(ENTRIES);
  localparam int MW      = SW + 8;

  localparam logic signed [52:0] Q_MAX = 53'sd2147483647;
  localparam logic signed [52:0] Q_MIN = -53'sd2147483648;

  function automatic logic [SW-1:0] state_mod(input logic [7:0] v);
    logic [MW-1:0] r;
    r = MW'(v);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (MW'(MAX_STATES) << k)) r = r - (MW'(MAX_STATES) << k);
    end
    return SW'(r);
  endfunction

  function automatic logic [EW-1:0] entry_idx(input logic [SW-1:0] s,
                                              input logic [AW-1:0] a);
    return EW'(s * MAX_ACTIONS) + EW'(a);
  endfunction

  function automatic logic [RATE_W-1:0] cap_one(input logic [RATE_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  // Configuration and architectural state.
  logic [4:0]        cfg_nact;
  logic [RATE_W-1:0] cfg_alpha, cfg_gamma, cfg_decay;
  logic [RATE_W-1:0] eps;
  logic [SW-1:0]     cur_state;
  logic [AW-1:0]     cur_action;

  // Latched request.
  req_t                  r_req;
  logic [7:0]            r_ts, r_tn;
  logic [3:0]            r_ta;
  logic                  r_tv;
  logic [RAND_W-1:0]     r_draw, r_pick;
  logic signed [Q_W-1:0] r_reward;

  // Memories.
  logic signed [Q_W-1:0] q_mem [ENTRIES];
  logic                  v_mem [ENTRIES];
  logic [SW-1:0]         n_mem [ENTRIES];
  logic signed [Q_W-1:0] q_dat;
  logic                  v_dat;
  logic [SW-1:0]         n_dat;
  logic [EW-1:0]         rd_addr, cur_idx, ld_idx, clr_addr;
  logic                  ld_en;

  // Scanner.
  logic                  scan_on, rd_live, found;
  scan_mode_t            scan_mode;
  logic [AW-1:0]         scan_act, rd_act, chosen;
  logic [SW-1:0]         scan_state;
  logic [CW-1:0]         n_used, count, ties, k;
  logic signed [Q_W-1:0] top;
  logic                  pick_match;

  // Remainder unit.
  logic               div_on;
  logic [PICK_IW-1:0] div_idx;
  logic [CW:0]        div_rem, div_t;
  logic [CW-1:0]      div_d;

  // Update arithmetic.
  logic signed [Q_W-1:0] q_old, maxq, res_q;
  logic [SW-1:0]         nxt;
  logic [RATE_W-1:0]     a_cap, g_cap;
  logic signed [49:0]    prod_g, p1;
  logic signed [33:0]    target;
  logic signed [51:0]    p2;
  logic signed [52:0]    sum, shifted;

  // Result fields of the item in flight.
  logic [AW-1:0]         res_action;
  logic                  res_explored, res_status;
  logic signed [Q_W-1:0] res_newq;
  logic                  explore_hit;

  always_comb begin
    if (cfg_nact == 5'd0) begin
      n_used = CW'(1);
    end else if (int'(cfg_nact) > MAX_ACTIONS) begin
      n_used = CW'(MAX_ACTIONS);
    end else begin
      n_used = CW'(cfg_nact);
    end
  end

  assign a_cap       = cap_one(cfg_alpha);
  assign g_cap       = cap_one(cfg_gamma);
  assign explore_hit = {1'b0, r_draw} <= eps;
  assign cur_idx     = entry_idx(cur_state, cur_action);
  assign ld_idx      = entry_idx(SW'(r_ts), AW'(r_ta));
  assign ld_en       = cmd.load_wr && (r_req == REQ_LOAD) &&
                       (int'(r_ts) < MAX_STATES) && (int'(r_ta) < MAX_ACTIONS);
  assign rd_addr     = cmd.rd_entry ? cur_idx : entry_idx(scan_state, scan_act);
  assign maxq        = (ties == '0) ? '0 : top;
  assign pick_match  = (scan_mode == SCAN_PICK_VALID) ? v_dat : (v_dat && q_dat == top);
  assign div_t       = {div_rem[CW-1:0], r_pick[div_idx]};
  assign sum         = 53'(p1) + 53'(p2);
  assign shifted     = sum >>> 16;

  always_comb begin
    if (shifted > Q_MAX) begin
      res_q = Q_MAX[31:0];
    end else if (shifted < Q_MIN) begin
      res_q = Q_MIN[31:0];
    end else begin
      res_q = shifted[31:0];
    end
  end

  assign sts.req         = r_req;
  assign sts.clr_done    = clr_addr == EW'(ENTRIES - 1);
  assign sts.scan_busy   = scan_on | rd_live;
  assign sts.div_busy    = div_on;
  assign sts.count_zero  = count == '0;
  assign sts.explore_hit = explore_hit;
  assign sts.out_free    = !out_valid || !out_stall;

  // Memories: the Q and valid stores are swept to zero after reset.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      q_mem[clr_addr] <= '0;
    end else if (cmd.wb) begin
      q_mem[cur_idx] <= res_q;
    end
    q_dat <= q_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      v_mem[clr_addr] <= 1'b0;
    end else if (ld_en) begin
      v_mem[ld_idx] <= r_tv;
    end
    v_dat <= v_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ld_en) n_mem[ld_idx] <= state_mod(r_tn);
    n_dat <= n_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !sts.clr_done) begin
      clr_addr <= clr_addr + EW'(1);
    end
  end

  // Configuration registers, epsilon, current state and action.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_nact   <= RST_ACTIONS;
      cfg_alpha  <= RST_ALPHA;
      cfg_gamma  <= RST_GAMMA;
      cfg_decay  <= RST_DECAY;
      eps        <= ONE_Q16;
      cur_state  <= '0;
      cur_action <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ACTIONS: cfg_nact  <= cfg_data[4:0];
          CFG_ALPHA:   cfg_alpha <= cfg_data;
          CFG_GAMMA:   cfg_gamma <= cfg_data;
          CFG_EPS0:    eps       <= cap_one(cfg_data);
          CFG_DECAY:   cfg_decay <= cfg_data;
          CFG_START:   cur_state <= state_mod(cfg_data[7:0]);
          default: ;
        endcase
      end
      if (cmd.commit) begin
        cur_action <= chosen;
        if (explore_hit) eps <= (eps > cfg_decay) ? eps - cfg_decay : '0;
      end
      if (cmd.wb) cur_state <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      r_req    <= req_t'(req_type);
      r_ts     <= table_state;
      r_ta     <= table_action;
      r_tv     <= table_valid;
      r_tn     <= table_next;
      r_draw   <= rand_explore;
      r_pick   <= rand_pick;
      r_reward <= reward;
    end
  end

  // Scanner: issues one read per cycle, consumes the data in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_on <= 1'b0;
      rd_live <= 1'b0;
    end else begin
      rd_live <= scan_on;
      if (cmd.scan_start) begin
        scan_on <= 1'b1;
      end else if (scan_on && CW'(scan_act) == n_used - CW'(1)) begin
        scan_on <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_act   <= '0;
      scan_mode  <= cmd.scan_mode;
      scan_state <= cmd.scan_from_next ? nxt : cur_state;
      if (cmd.scan_mode == SCAN_STATS) begin
        count <= '0;
        ties  <= '0;
        top   <= '0;
      end else begin
        k     <= '0;
        found <= 1'b0;
      end
    end else begin
      if (scan_on) begin
        rd_act   <= scan_act;
        scan_act <= scan_act + AW'(1);
      end
      if (rd_live) begin
        if (scan_mode == SCAN_STATS) begin
          if (v_dat) begin
            count <= count + CW'(1);
            if (ties == '0 || q_dat > top) begin
              top  <= q_dat;
              ties <= CW'(1);
            end else if (q_dat == top) begin
              ties <= ties + CW'(1);
            end
          end
        end else if (pick_match && !found) begin
          if (k == div_rem[CW-1:0]) begin
            chosen <= rd_act;
            found  <= 1'b1;
          end
          k <= k + CW'(1);
        end
      end
    end
  end

  // Remainder of the pick by the count or tie count, one bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_on <= 1'b0;
    end else if (cmd.div_start) begin
      div_on <= 1'b1;
    end else if (div_on && div_idx == '0) begin
      div_on <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem <= '0;
      div_idx <= PICK_IW'(RAND_W - 1);
      div_d   <= explore_hit ? count : ties;
    end else if (div_on) begin
      div_rem <= (div_t >= {1'b0, div_d}) ? div_t - {1'b0, div_d} : div_t;
      div_idx <= div_idx - PICK_IW'(1);
    end
  end

  // Q update: Q' = floor(((1 - a) Q + a (r + floor(g maxQ))) / 2^16).
  always_ff @(posedge clk) begin
    if (cmd.entry_latch) begin
      q_old <= q_dat;
      nxt   <= n_dat;
    end
    if (cmd.mul_g) prod_g <= $signed({1'b0, g_cap}) * maxq;
    if (cmd.tgt) begin
      target <= 34'(r_reward) + 34'(prod_g >>> 16);
      p1     <= $signed({1'b0, ONE_Q16 - a_cap}) * q_old;
    end
    if (cmd.mul_a) p2 <= $signed({1'b0, a_cap}) * target;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_clear) begin
      res_action   <= '0;
      res_explored <= 1'b0;
      res_status   <= 1'b0;
      res_newq     <= '0;
    end else begin
      if (cmd.no_valid) res_status <= 1'b1;
      if (cmd.commit) begin
        res_action   <= chosen;
        res_explored <= explore_hit;
      end
      if (cmd.wb) res_newq <= res_q;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      action      <= 4'(res_action);
      explored    <= res_explored;
      status      <= res_status;
      new_q       <= res_newq;
      epsilon_now <= eps;
      state_now   <= 8'(cur_state);
    end
  end

  a_scan_div_excl: assert property (@(posedge clk) disable iff (rst)
    !(sts.scan_busy && div_on))
    else $error("scanner and remainder unit active together");
  a_live_follows_issue: assert property (@(posedge clk) disable iff (rst)
    rd_live |-> $past(scan_on))
    else $error("read data consumed without a read issued");
  a_eps_cap: assert property (@(posedge clk) disable iff (rst)
    eps <= ONE_Q16)
    else $error("epsilon above one");
  a_commit_found: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> found)
    else $error("action committed before the pick scan found it");

endmodule

// File: rtl/core/q_learning_agent_top.sv
// Top level of the tabular Q-learning agent with epsilon-greedy choice.
// Instantiates qla_ctrl and qla_dp; uses qla_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------
//   cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//   in      | in        | in_valid/in_stall  | req_type, table_*, rand_*, reward
//   out     | out       | out_valid/out_stall| action, explored, status, new_q,
//           |           |                    | epsilon_now, state_now
//
// After reset the block sweeps the Q and valid memories to zero, one entry per
// cycle, over all MAX_STATES * MAX_ACTIONS entries; in_stall stays high meanwhile.
// A load item is decoded, written to the tables and passed to the output register.
// A choose item makes one memory read per action in use in a statistics scan,
// works out the remainder of the 16-bit pick, and runs a second scan.
// A reward item makes an entry read, a scan of the next state and three
// registered multiplies. One item is in work at a time.
// The finished result sits in an output register, so the next item is accepted
// while a result still waits on out_stall. Configuration writes are always
// taken (cfg_ready is tied high) and are meant to arrive only while idle.
module q_learning_agent_top import qla_pkg::*; #(
  parameter int MAX_STATES  = 256,
  parameter int MAX_ACTIONS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            req_type,
  input  logic [7:0]            table_state,
  input  logic [3:0]            table_action,
  input  logic                  table_valid,
  input  logic [7:0]            table_next,
  input  logic [RAND_W-1:0]     rand_explore,
  input  logic [RAND_W-1:0]     rand_pick,
  input  logic signed [Q_W-1:0] reward,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [3:0]            action,
  output logic                  explored,
  output logic                  status,
  output logic signed [Q_W-1:0] new_q,
  output logic [RATE_W-1:0]     epsilon_now,
  output logic [7:0]            state_now
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // Register writes are taken at once, so the port never holds off.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  qla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  qla_dp #(
    .MAX_STATES  (MAX_STATES),
    .MAX_ACTIONS (MAX_ACTIONS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .table_state  (table_state),
    .table_action (table_action),
    .table_valid  (table_valid),
    .table_next   (table_next),
    .rand_explore (rand_explore),
    .rand_pick    (rand_pick),
    .reward       (reward),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .action       (action),
    .explored     (explored),
    .status       (status),
    .new_q        (new_q),
    .epsilon_now  (epsilon_now),
    .state_now    (state_now)
  );

  a_in_out_excl: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !cmd.out_load)
    else $error("input accepted while a result is being loaded");
  a_load_once: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> !cmd.out_load)
    else $error("one item produced two results");
  a_cfg_ready_high: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_we)
    else $error("configuration write not taken");

endmodule

// File: dv/qla_checker.sv
// Scoreboard for the Q-learning agent: watches the config, input and output
// channels, predicts every result and compares it field by field.
// Depends on qla_pkg for request codes, register indexes and widths.
module qla_checker import qla_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [1:0]            req_type,
  input  logic [7:0]            table_state,
  input  logic [3:0]            table_action,
  input  logic                  table_valid,
  input  logic [7:0]            table_next,
  input  logic [RAND_W-1:0]     rand_explore,
  input  logic [RAND_W-1:0]     rand_pick,
  input  logic signed [Q_W-1:0] reward,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [3:0]            action,
  input  logic                  explored,
  input  logic                  status,
  input  logic signed [Q_W-1:0] new_q,
  input  logic [RATE_W-1:0]     epsilon_now,
  input  logic [7:0]            state_now,
  output int                    errors,
  output int                    pending,
  output int                    n_choose,
  output int                    n_explore,
  output int                    n_blocked,
  output int                    n_reward
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]            action;
    logic                  explored;
    logic                  status;
    logic signed [Q_W-1:0] new_q;
    logic [RATE_W-1:0]     eps;
    logic [7:0]            state;
  } agent_result_t;

  agent_result_t expected_results[$];

  logic signed [Q_W-1:0] q_mem [4096];
  bit                    valid_mem [4096];
  logic [7:0]            next_mem [4096];
  logic [4:0]            m_acts;
  logic [RATE_W-1:0]     m_alpha, m_gamma, m_decay, m_eps;
  logic [7:0]            m_state;
  logic [3:0]            m_action;

  assign pending = expected_results.size();

  function automatic logic [RATE_W-1:0] cap_one(input logic [RATE_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic int unsigned acts_used();
    if (m_acts < 1) return 1;
    if (m_acts > 16) return 16;
    return m_acts;
  endfunction

  // Number of valid actions tied at the top Q of state s; best gets the tie
  // selected by pick.
  function automatic int unsigned top_actions(input logic [7:0] s, input int unsigned pick,
                                               output logic [3:0] best,
                                               output logic signed [Q_W-1:0] top);
    int unsigned ties, k, sel;
    ties = 0;
    k = 0;
    top = '0;
    best = '0;
    for (int a = 0; a < acts_used(); a++) begin
      if (!valid_mem[{s, a[3:0]}]) continue;
      if (ties == 0 || q_mem[{s, a[3:0]}] > top) begin
        top = q_mem[{s, a[3:0]}];
        ties = 1;
      end else if (q_mem[{s, a[3:0]}] == top) begin
        ties++;
      end
    end
    if (ties == 0) return 0;
    sel = pick % ties;
    for (int a = 0; a < acts_used(); a++) begin
      if (valid_mem[{s, a[3:0]}] && q_mem[{s, a[3:0]}] == top) begin
        if (k == sel) begin
          best = a[3:0];
          break;
        end
        k++;
      end
    end
    return ties;
  endfunction

  task automatic predict(output agent_result_t r);
    int unsigned count, sel, k;
    logic [11:0] i;
    logic [7:0] nx;
    logic [3:0] pickd;
    logic signed [Q_W-1:0] mq;
    longint al, ga, tg, sm, rs;
    r = '0;
    if (req_type == REQ_LOAD) begin
      valid_mem[{table_state, table_action}] = table_valid;
      next_mem[{table_state, table_action}] = table_next;
    end else if (req_type == REQ_CHOOSE) begin
      n_choose++;
      count = 0;
      for (int a = 0; a < acts_used(); a++)
        if (valid_mem[{m_state, a[3:0]}]) count++;
      if (count == 0) begin
        r.status = 1'b1;
        n_blocked++;
      end else if (rand_explore <= m_eps) begin
        sel = rand_pick % count;
        k = 0;
        pickd = '0;
        for (int a = 0; a < acts_used(); a++) begin
          if (valid_mem[{m_state, a[3:0]}]) begin
            if (k == sel) begin
              pickd = a[3:0];
              break;
            end
            k++;
          end
        end
        m_eps = (m_eps > m_decay) ? m_eps - m_decay : '0;
        m_action = pickd;
        r.action = pickd;
        r.explored = 1'b1;
        n_explore++;
      end else begin
        void'(top_actions(m_state, rand_pick, pickd, mq));
        m_action = pickd;
        r.action = pickd;
      end
    end else if (req_type == REQ_REWARD) begin
      n_reward++;
      i = {m_state, m_action};
      nx = next_mem[i];
      // A next state with no valid action is terminal and contributes zero.
      if (top_actions(nx, 0, pickd, mq) == 0) mq = '0;
      al = cap_one(m_alpha);
      ga = cap_one(m_gamma);
      tg = longint'(reward) + ((ga * longint'(mq)) >>> 16);
      sm = (64'sd65536 - al) * longint'(q_mem[i]) + al * tg;
      rs = sm >>> 16;
      if (rs > 64'sd2147483647) rs = 64'sd2147483647;
      if (rs < -64'sd2147483648) rs = -64'sd2147483648;
      q_mem[i] = rs[31:0];
      r.new_q = rs[31:0];
      m_state = nx;
    end
    r.eps = m_eps;
    r.state = m_state;
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    agent_result_t e;
    if (rst) begin
      expected_results.delete();
      for (int i = 0; i < 4096; i++) begin
        q_mem[i] = '0;
        valid_mem[i] = 1'b0;
        next_mem[i] = '0;
      end
      m_acts = RST_ACTIONS;
      m_alpha = RST_ALPHA;
      m_gamma = RST_GAMMA;
      m_decay = RST_DECAY;
      m_state = '0;
      m_action = '0;
      m_eps = ONE_Q16;
      errors = 0;
      n_choose = 0;
      n_explore = 0;
      n_blocked = 0;
      n_reward = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ACTIONS: m_acts = cfg_data[4:0];
          CFG_ALPHA:   m_alpha = cfg_data;
          CFG_GAMMA:   m_gamma = cfg_data;
          CFG_EPS0:    m_eps = cap_one(cfg_data);
          CFG_DECAY:   m_decay = cfg_data;
          CFG_START:   m_state = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected, actual action %0d new_q %0d",
                   $time, action, new_q);
        end else begin
          e = expected_results.pop_front();
          check_field("action", e.action, action);
          check_field("explored", e.explored, explored);
          check_field("status", e.status, status);
          check_field("new_q", e.new_q, new_q);
          check_field("epsilon_now", e.eps, epsilon_now);
          check_field("state_now", e.state, state_now);
        end
      end
      if (in_valid && !in_stall) begin
        predict(e);
        expected_results = {expected_results, e};
      end
    end
  end

endmodule

// File: dv/testbench.sv
// Top of the Q-learning agent testbench: clock, reset, stimulus, stall
// generation, watchdog and verdict. Instantiates q_learning_agent_top and
// qla_checker; uses qla_pkg.
module testbench import qla_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code that the block must treat as a no-op.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int NUM_PHASES = 6;
  localparam int RANDOM_PER_PHASE = 120;
  localparam int STALL_LIMIT = 20000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            req_type = '0;
  logic [7:0]            table_state = '0;
  logic [3:0]            table_action = '0;
  logic                  table_valid = 1'b0;
  logic [7:0]            table_next = '0;
  logic [RAND_W-1:0]     rand_explore = '0;
  logic [RAND_W-1:0]     rand_pick = '0;
  logic signed [Q_W-1:0] reward = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [3:0]            action;
  logic                  explored;
  logic                  status;
  logic signed [Q_W-1:0] new_q;
  logic [RATE_W-1:0]     epsilon_now;
  logic [7:0]            state_now;

  int errors, pending, n_choose, n_explore, n_blocked, n_reward;
  int idle_cycles = 0;
  int stall_left = 0;
  int items_sent = 0;
  // While calm is set neither side inserts gaps, so back-to-back transfers occur.
  bit calm = 1'b0;
  // The states the agent can reach in the current phase. Every action of each
  // of them is loaded with a next state inside the same set, so a reward
  // never reads a next-state entry that was never written.
  logic [7:0] world [8];

  always #5 clk = ~clk;

  q_learning_agent_top uut (.*);

  qla_checker scoreboard (.*);

  // Result side: random stalls, mostly short bursts and the odd long one.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(99) < 25) begin
      stall_left <= ($urandom_range(99) < 85) ? $urandom_range(2) : $urandom_range(49, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    int k;
    if (calm) return 0;
    k = $urandom_range(99);
    if (k < 65) return 0;
    if (k < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic bit in_world(input logic [7:0] s);
    foreach (world[i]) if (world[i] == s) return 1'b1;
    return 1'b0;
  endfunction

  // Presents one item and returns at the edge where its transfer happens.
  task automatic send_item(input logic [1:0] rt, input logic [7:0] ts, input logic [3:0] ta,
                           input logic tv, input logic [7:0] tn, input logic [15:0] re,
                           input logic [15:0] rp, input logic [31:0] rw);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    table_state <= ts;
    table_action <= ta;
    table_valid <= tv;
    table_next <= tn;
    rand_explore <= re;
    rand_pick <= rp;
    reward <= rw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Lets every expected result drain before the block is reconfigured.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_item();
    int k;
    logic [7:0] s;
    logic [31:0] rw;
    k = $urandom_range(99);
    if (k < 18) begin
      // Reload an entry of the reachable set with fresh content.
      send_item(REQ_LOAD, world[$urandom_range(7)], 4'($urandom_range(15)),
                $urandom_range(9) < 7, world[$urandom_range(7)], 16'($urandom),
                16'($urandom), $urandom);
    end else if (k < 22) begin
      // Noise: the unused request code, or a load of a state nobody reaches.
      if (k < 20) begin
        send_item(REQ_UNUSED, 8'($urandom), 4'($urandom), 1'($urandom), 8'($urandom),
                  16'($urandom), 16'($urandom), $urandom);
      end else begin
        s = 8'($urandom);
        while (in_world(s)) s = 8'($urandom);
        send_item(REQ_LOAD, s, 4'($urandom), 1'($urandom), 8'($urandom), 16'($urandom),
                  16'($urandom), $urandom);
      end
    end else if (k < 60) begin
      send_item(REQ_CHOOSE, 8'($urandom), 4'($urandom), 1'($urandom), 8'($urandom),
                16'($urandom_range(65535)), 16'($urandom_range(65535)), $urandom);
    end else begin
      case ($urandom_range(15))
        0: rw = 32'h7fffffff;
        1: rw = 32'h80000000;
        2: rw = 32'hffffffff;
        3: rw = $urandom;
        default: rw = $urandom_range(32'h000fffff) - 32'h00080000;
      endcase
      send_item(REQ_REWARD, 8'($urandom), 4'($urandom), 1'($urandom), 8'($urandom),
                16'($urandom), 16'($urandom), rw);
    end
  endtask

  // Register settings per phase, reset values first and the extremes after.
  int unsigned ph_acts  [NUM_PHASES] = '{16, 1, 0, 31, 5, 12};
  int unsigned ph_alpha [NUM_PHASES] = '{6554, 65536, 0, 131071, 30000, 65535};
  int unsigned ph_gamma [NUM_PHASES] = '{58982, 0, 65536, 131071, 45000, 1};
  int unsigned ph_eps0  [NUM_PHASES] = '{65536, 32768, 0, 131071, 20000, 65536};
  int unsigned ph_decay [NUM_PHASES] = '{66, 0, 65536, 131071, 500, 3000};

  initial begin
    bit terminal;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // The block clears its memories after reset and holds in_stall meanwhile.
    @(posedge clk);
    while (in_stall) @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      foreach (world[i]) world[i] = 8'($urandom);
      if (p == 0) begin
        world[0] = 8'd0;
        world[1] = 8'd255;
      end

      write_reg(CFG_ACTIONS, CFG_DATA_W'(ph_acts[p]));
      write_reg(CFG_ALPHA, CFG_DATA_W'(ph_alpha[p]));
      write_reg(CFG_GAMMA, CFG_DATA_W'(ph_gamma[p]));
      write_reg(CFG_EPS0, CFG_DATA_W'(ph_eps0[p]));
      write_reg(CFG_DECAY, CFG_DATA_W'(ph_decay[p]));
      write_reg(CFG_START, CFG_DATA_W'(world[$urandom_range(7)]));
      cfg_valid <= 1'b0;

      // Load the full reachable set; the last state gets no valid action,
      // so it acts as a terminal state.
      calm = (p == 2);
      for (int s = 0; s < 8; s++) begin
        for (int a = 0; a < 16; a++) begin
          terminal = (s == 7);
          send_item(REQ_LOAD, world[s], 4'(a), !terminal && ($urandom_range(3) != 0),
                    world[$urandom_range(7)], 16'($urandom), 16'($urandom), $urandom);
        end
      end

      if (p == 0) begin
        // Directed corners: the unused code, draw and pick extremes, reward
        // saturation in both directions, and a load of state 255, action 15 back to state 0.
        send_item(REQ_UNUSED, '1, '1, 1'b1, '1, '1, '1, '1);
        send_item(REQ_CHOOSE, '0, '0, 1'b0, '0, 16'd0, 16'hffff, '0);
        send_item(REQ_REWARD, '0, '0, 1'b0, '0, '0, '0, 32'h7fffffff);
        send_item(REQ_CHOOSE, '0, '0, 1'b0, '0, 16'hffff, 16'd0, '0);
        send_item(REQ_REWARD, '0, '0, 1'b0, '0, '0, '0, 32'h80000000);
        send_item(REQ_CHOOSE, '0, '0, 1'b0, '0, 16'hffff, 16'hffff, '0);
        send_item(REQ_REWARD, '0, '0, 1'b0, '0, '0, '0, 32'h7fffffff);
        send_item(REQ_REWARD, '0, '0, 1'b0, '0, '0, '0, 32'h7fffffff);
        send_item(REQ_CHOOSE, '0, '0, 1'b0, '0, 16'd0, 16'd0, '0);
        send_item(REQ_REWARD, '0, '0, 1'b0, '0, '0, '0, 32'h80000000);
        send_item(REQ_REWARD, '0, '0, 1'b0, '0, '0, '0, 32'h80000000);
        send_item(REQ_REWARD, '0, '0, 1'b0, '0, '0, '0, 32'h00000000);
        send_item(REQ_REWARD, '0, '0, 1'b0, '0, '0, '0, 32'hffffffff);
        send_item(REQ_LOAD, world[1], 4'hf, 1'b1, world[0], '1, '1, '1);
        send_item(REQ_CHOOSE, '0, '0, 1'b0, '0, 16'h8000, 16'h0001, '0);
      end

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Alternate stretches with and without gaps on both sides.
        if (n % 40 == 0) calm = ($urandom_range(3) == 0);
        random_item();
      end
      calm = 1'b0;
      drain();
    end

    repeat (60) @(posedge clk);
    $display("Sent %0d items over %0d register settings: %0d choices (%0d explored, %0d blocked),",
             items_sent, NUM_PHASES, n_choose, n_explore, n_blocked);
    $display("%0d Q updates, %0d mismatches.", n_reward, errors);
    if (errors == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
